// File: rtl/smbios_memory_record_scanner_unit_defines.svh
// ----------------------------------------------------------------------------
// smbios_memory_record_scanner_unit_defines
// assertion macros shared by the scanner modules
// ----------------------------------------------------------------------------
`ifndef SMBIOS_MEMORY_RECORD_SCANNER_UNIT_DEFINES_SVH
`define SMBIOS_MEMORY_RECORD_SCANNER_UNIT_DEFINES_SVH

// plain condition checked at every rising clock edge out of reset
`define SMRS_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("smrs assertion failed");

// same-cycle implication
`define SMRS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smrs assertion failed");

// next-cycle implication
`define SMRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smrs assertion failed");

`endif

// File: rtl/smrs_pkg.sv
// ----------------------------------------------------------------------------
// smrs_pkg
// types and constants of the smbios memory record scanner
// ----------------------------------------------------------------------------
`default_nettype none

package smrs_pkg;

  // captured fixed-offset bytes of a memory device record
  localparam int CAP_NUM = 20;
  typedef logic [CAP_NUM-1:0][7:0] cap_t;

  localparam logic [7:0] CAP_OFF [CAP_NUM] = '{
    8'h0c, 8'h0d, 8'h0e, 8'h12, 8'h15, 8'h16, 8'h1c, 8'h1d, 8'h1e, 8'h1f,
    8'h20, 8'h21, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5a, 8'h5b
  };

  localparam int CI_SIZE      = 0;
  localparam int CI_FORM      = 2;
  localparam int CI_MTYPE     = 3;
  localparam int CI_RATED     = 4;
  localparam int CI_EXT_SIZE  = 6;
  localparam int CI_CONF      = 10;
  localparam int CI_EXT_RATED = 12;
  localparam int CI_EXT_CONF  = 16;

  // record length thresholds
  localparam logic [7:0] MIN_LEN       = 8'd4;
  localparam logic [7:0] LEN_SIZE      = 8'h0d;
  localparam logic [7:0] LEN_FORM      = 8'h0e;
  localparam logic [7:0] LEN_MTYPE     = 8'h12;
  localparam logic [7:0] LEN_RATED     = 8'h17;
  localparam logic [7:0] LEN_EXT_SIZE  = 8'h20;
  localparam logic [7:0] LEN_CONF      = 8'h22;
  localparam logic [7:0] LEN_EXT_RATED = 8'h58;
  localparam logic [7:0] LEN_EXT_CONF  = 8'h5c;

  localparam logic [7:0] TYPE_MEMDEV = 8'd17;
  localparam logic [7:0] TYPE_END    = 8'd127;

  localparam logic [15:0] SIZE_EXT  = 16'h7fff;
  localparam logic [15:0] SIZE_NONE = 16'hffff;
  localparam logic [31:0] SPEED_EXT = 32'h0000ffff;
  localparam logic [15:0] CNT_SAT   = 16'hffff;

  localparam logic [7:0] FORM_MAX     = 8'd16;
  localparam logic [7:0] FORM_UNKNOWN = 8'd2;

  localparam logic KIND_MODULE  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam int RES_DEPTH = 4;

  // record close / table end event from parser to decoder
  typedef struct packed {
    logic       valid;
    logic       close_memdev;
    logic       last;
    logic [7:0] len;
  } ev_t;

  typedef struct packed {
    logic        kind;
    logic [51:0] module_size_bytes;
    logic [31:0] module_speed;
    logic [7:0]  module_form_code;
    logic [7:0]  module_type_code;
    logic [15:0] total_slots;
    logic [15:0] used_slots;
    logic [31:0] lowest_speed;
    logic [4:0]  table_form_code;
    logic        status;
    logic        final_result;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/smrs_in_if.sv
// ----------------------------------------------------------------------------
// smrs_in_if
// table byte channel
// ----------------------------------------------------------------------------
`default_nettype none

interface smrs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] table_byte;
  logic       last_byte;

  modport source (output valid, output table_byte, output last_byte, input ready);
  modport sink (input valid, input table_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/smrs_out_if.sv
// ----------------------------------------------------------------------------
// smrs_out_if
// result channel
// ----------------------------------------------------------------------------
`default_nettype none

interface smrs_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [51:0] module_size_bytes;
  logic [31:0] module_speed;
  logic [7:0]  module_form_code;
  logic [7:0]  module_type_code;
  logic [15:0] total_slots;
  logic [15:0] used_slots;
  logic [31:0] lowest_speed;
  logic [4:0]  table_form_code;
  logic        status;
  logic        final_result;

  modport source (
    output valid, output kind, output module_size_bytes, output module_speed,
    output module_form_code, output module_type_code, output total_slots,
    output used_slots, output lowest_speed, output table_form_code,
    output status, output final_result, input ready
  );
  modport sink (
    input valid, input kind, input module_size_bytes, input module_speed,
    input module_form_code, input module_type_code, input total_slots,
    input used_slots, input lowest_speed, input table_form_code,
    input status, input final_result, output ready
  );
endinterface

`default_nettype wire

// File: rtl/smrs_parser.sv
// ----------------------------------------------------------------------------
// smrs_parser
// frames structures, captures fixed fields, flags memory device record close and table end
// ----------------------------------------------------------------------------
`default_nettype none
`include "smbios_memory_record_scanner_unit_defines.svh"

module smrs_parser (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       table_byte,
  input  wire logic             last_byte,
  input  wire logic             ev_take,
  output smrs_pkg::ev_t         ev_o,
  output smrs_pkg::cap_t        cap_o
);

  typedef enum logic [1:0] {PH_TYPE, PH_LEN, PH_BODY, PH_STR} phase_t;

  phase_t         phase_r, phase_nxt;
  logic [7:0]     pos_r, pos_nxt;
  logic [7:0]     rtype_r, rtype_nxt;
  logic [7:0]     rlen_r, rlen_nxt;
  logic           prev_zero_r, prev_zero_nxt;
  logic           stopped_r, stopped_nxt;
  smrs_pkg::ev_t  ev_r, ev_nxt;
  smrs_pkg::cap_t cap_r;
  logic           in_acc;
  logic           close;
  logic [7:0]     pos_inc;

  assign in_ready = !ev_r.valid || ev_take;
  assign in_acc   = in_valid && in_ready;
  assign pos_inc  = pos_r + 8'd1;
  assign ev_o     = ev_r;
  assign cap_o    = cap_r;

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    rtype_nxt     = rtype_r;
    rlen_nxt      = rlen_r;
    prev_zero_nxt = prev_zero_r;
    stopped_nxt   = stopped_r;
    close         = 1'b0;
    ev_nxt        = ev_r;
    if (ev_take) begin
      ev_nxt.valid = 1'b0;
    end
    if (in_acc) begin
      if (!stopped_r) begin
        unique case (phase_r)
          PH_TYPE: begin
            rtype_nxt = table_byte;
            pos_nxt   = 8'd1;
            phase_nxt = PH_LEN;
          end
          PH_LEN: begin
            rlen_nxt = table_byte;
            if (table_byte < smrs_pkg::MIN_LEN) begin
              stopped_nxt = 1'b1;
            end else begin
              pos_nxt   = 8'd2;
              phase_nxt = PH_BODY;
            end
          end
          PH_BODY: begin
            pos_nxt = pos_inc;
            if (pos_inc >= rlen_r) begin
              phase_nxt     = PH_STR;
              prev_zero_nxt = 1'b0;
            end
          end
          PH_STR: begin
            if (table_byte == 8'd0 && prev_zero_r) begin
              close = 1'b1;
            end else begin
              prev_zero_nxt = (table_byte == 8'd0);
            end
          end
          default: begin
            phase_nxt = PH_TYPE;
          end
        endcase
      end
      if (close) begin
        if (rtype_r == smrs_pkg::TYPE_END) begin
          stopped_nxt = 1'b1;
        end
        phase_nxt     = PH_TYPE;
        pos_nxt       = 8'd0;
        prev_zero_nxt = 1'b0;
      end
      ev_nxt.close_memdev = close && (rtype_r == smrs_pkg::TYPE_MEMDEV);
      ev_nxt.last         = last_byte;
      ev_nxt.len          = rlen_r;
      ev_nxt.valid        = ev_nxt.close_memdev || last_byte;
      if (last_byte) begin
        phase_nxt     = PH_TYPE;
        pos_nxt       = 8'd0;
        rtype_nxt     = 8'd0;
        rlen_nxt      = 8'd0;
        prev_zero_nxt = 1'b0;
        stopped_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TYPE;
      pos_r       <= 8'd0;
      rtype_r     <= 8'd0;
      rlen_r      <= 8'd0;
      prev_zero_r <= 1'b0;
      stopped_r   <= 1'b0;
      ev_r        <= '0;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      rtype_r     <= rtype_nxt;
      rlen_r      <= rlen_nxt;
      prev_zero_r <= prev_zero_nxt;
      stopped_r   <= stopped_nxt;
      ev_r        <= ev_nxt;
    end
  end

  // fixed-offset field capture
  always_ff @(posedge clk) begin
    for (int i = 0; i < smrs_pkg::CAP_NUM; i++) begin
      if (in_acc && !stopped_r && phase_r == PH_BODY && pos_r == smrs_pkg::CAP_OFF[i]) begin
        cap_r[i] <= table_byte;
      end
    end
  end

  `SMRS_ASSERT_NEXT(a_last_rearms, in_acc && last_byte, phase_r == PH_TYPE && !stopped_r)
  `SMRS_ASSERT_IMPL(a_str_len_ok, phase_r == PH_STR, rlen_r >= smrs_pkg::MIN_LEN)

endmodule

`default_nettype wire

// File: rtl/smrs_decoder.sv
// ----------------------------------------------------------------------------
// smrs_decoder
// decodes a closed memory device record, keeps table statistics, forms results
// ----------------------------------------------------------------------------
`default_nettype none
`include "smbios_memory_record_scanner_unit_defines.svh"

module smrs_decoder #(
  parameter int MAX_MODULES = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire smrs_pkg::ev_t  ev_i,
  input  wire smrs_pkg::cap_t cap_i,
  input  wire logic           room_i,
  output logic                ev_take,
  output logic [1:0]          push_cnt,
  output smrs_pkg::res_t      push0,
  output smrs_pkg::res_t      push1
);

  localparam int MC_W = $clog2(MAX_MODULES + 1);

  logic [15:0]     slot_r, used_r;
  logic [31:0]     min_r;
  logic [4:0]      form_r;
  logic [MC_W-1:0] mcnt_r;

  logic [15:0]     slot_upd, used_upd;
  logic [31:0]     min_upd;
  logic [4:0]      form_upd;
  logic [MC_W-1:0] mcnt_upd;

  logic [15:0] enc;
  logic [31:0] ext_size, ext_rated, ext_conf, rated, conf, spd;
  logic        size_ok, ext_ok, populated, form_known, emit;
  logic [51:0] size;
  logic [7:0]  form_b, mtype_b;
  smrs_pkg::res_t mod_res, sum_res;

  assign ev_take = ev_i.valid && room_i;

  always_comb begin
    enc = {cap_i[smrs_pkg::CI_SIZE+1], cap_i[smrs_pkg::CI_SIZE]};
    ext_size = {cap_i[smrs_pkg::CI_EXT_SIZE+3], cap_i[smrs_pkg::CI_EXT_SIZE+2],
                cap_i[smrs_pkg::CI_EXT_SIZE+1], cap_i[smrs_pkg::CI_EXT_SIZE]};
    ext_rated = {cap_i[smrs_pkg::CI_EXT_RATED+3], cap_i[smrs_pkg::CI_EXT_RATED+2],
                 cap_i[smrs_pkg::CI_EXT_RATED+1], cap_i[smrs_pkg::CI_EXT_RATED]};
    ext_conf = {cap_i[smrs_pkg::CI_EXT_CONF+3], cap_i[smrs_pkg::CI_EXT_CONF+2],
                cap_i[smrs_pkg::CI_EXT_CONF+1], cap_i[smrs_pkg::CI_EXT_CONF]};

    size_ok   = (ev_i.len > smrs_pkg::LEN_SIZE) && (enc != 16'h0000) &&
                (enc != smrs_pkg::SIZE_NONE);
    ext_ok    = ev_i.len >= smrs_pkg::LEN_EXT_SIZE;
    populated = size_ok && ((enc != smrs_pkg::SIZE_EXT) || (ext_ok && ext_size != 32'd0));

    priority if (!size_ok) begin
      size = 52'd0;
    end else if (enc == smrs_pkg::SIZE_EXT) begin
      size = ext_ok ? {ext_size, 20'h00000} : 52'd0;
    end else if (enc[15]) begin
      size = {27'd0, enc[14:0], 10'd0};
    end else begin
      size = {16'd0, enc, 20'h00000};
    end

    // speed: configured if set, else rated
    rated = 32'd0;
    conf  = 32'd0;
    if (ev_i.len >= smrs_pkg::LEN_RATED) begin
      rated = {16'd0, cap_i[smrs_pkg::CI_RATED+1], cap_i[smrs_pkg::CI_RATED]};
    end
    if (ev_i.len >= smrs_pkg::LEN_CONF) begin
      conf = {16'd0, cap_i[smrs_pkg::CI_CONF+1], cap_i[smrs_pkg::CI_CONF]};
    end
    if (rated == smrs_pkg::SPEED_EXT && ev_i.len >= smrs_pkg::LEN_EXT_RATED) begin
      rated = ext_rated;
    end
    if (conf == smrs_pkg::SPEED_EXT && ev_i.len >= smrs_pkg::LEN_EXT_CONF) begin
      conf = ext_conf;
    end
    if (conf == smrs_pkg::SPEED_EXT) begin
      conf = 32'd0;
    end
    if (rated == smrs_pkg::SPEED_EXT) begin
      rated = 32'd0;
    end
    spd = (conf != 32'd0) ? conf : rated;

    form_b     = (ev_i.len > smrs_pkg::LEN_FORM) ? cap_i[smrs_pkg::CI_FORM] : 8'd0;
    mtype_b    = (ev_i.len > smrs_pkg::LEN_MTYPE) ? cap_i[smrs_pkg::CI_MTYPE] : 8'd0;
    form_known = (form_b >= 8'd1) && (form_b <= smrs_pkg::FORM_MAX) &&
                 (form_b != smrs_pkg::FORM_UNKNOWN);

    emit = ev_i.close_memdev && populated && (mcnt_r < MC_W'(MAX_MODULES));

    // statistics including this record
    slot_upd = slot_r;
    used_upd = used_r;
    min_upd  = min_r;
    form_upd = form_r;
    mcnt_upd = mcnt_r;
    if (ev_i.close_memdev) begin
      if (slot_r != smrs_pkg::CNT_SAT) begin
        slot_upd = slot_r + 16'd1;
      end
      if (populated) begin
        if (used_r != smrs_pkg::CNT_SAT) begin
          used_upd = used_r + 16'd1;
        end
        if (spd != 32'd0 && (min_r == 32'd0 || spd < min_r)) begin
          min_upd = spd;
        end
        if (form_r == 5'd0 && form_known) begin
          form_upd = form_b[4:0];
        end
      end
    end
    if (emit) begin
      mcnt_upd = mcnt_r + MC_W'(1);
    end

    mod_res                   = '0;
    mod_res.kind              = smrs_pkg::KIND_MODULE;
    mod_res.module_size_bytes = size;
    mod_res.module_speed      = spd;
    mod_res.module_form_code  = form_b;
    mod_res.module_type_code  = mtype_b;
    mod_res.final_result      = !ev_i.last;

    sum_res                 = '0;
    sum_res.kind            = smrs_pkg::KIND_SUMMARY;
    sum_res.total_slots     = slot_upd;
    sum_res.used_slots      = used_upd;
    sum_res.lowest_speed    = min_upd;
    sum_res.table_form_code = form_upd;
    sum_res.status          = (slot_upd == 16'd0);
    sum_res.final_result    = 1'b1;

    push0    = emit ? mod_res : sum_res;
    push1    = sum_res;
    push_cnt = ev_take ? ({1'b0, emit} + {1'b0, ev_i.last}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= 16'd0;
      used_r <= 16'd0;
      min_r  <= 32'd0;
      form_r <= 5'd0;
      mcnt_r <= '0;
    end else if (ev_take) begin
      if (ev_i.last) begin
        slot_r <= 16'd0;
        used_r <= 16'd0;
        min_r  <= 32'd0;
        form_r <= 5'd0;
        mcnt_r <= '0;
      end else begin
        slot_r <= slot_upd;
        used_r <= used_upd;
        min_r  <= min_upd;
        form_r <= form_upd;
        mcnt_r <= mcnt_upd;
      end
    end
  end

  `SMRS_ASSERT(a_used_le_slots, used_r <= slot_r)

endmodule

`default_nettype wire

// File: rtl/smrs_result_fifo.sv
// ----------------------------------------------------------------------------
// smrs_result_fifo
// result queue, up to two writes and one read per cycle
// ----------------------------------------------------------------------------
`default_nettype none
`include "smbios_memory_record_scanner_unit_defines.svh"

module smrs_result_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [1:0]     push_cnt,
  input  wire smrs_pkg::res_t push0,
  input  wire smrs_pkg::res_t push1,
  output logic                room_o,
  output logic                out_valid,
  input  wire logic           out_ready,
  output smrs_pkg::res_t      out_data
);

  localparam int PTR_W = $clog2(smrs_pkg::RES_DEPTH);
  localparam int CNT_W = $clog2(smrs_pkg::RES_DEPTH + 1);

  smrs_pkg::res_t q_r [smrs_pkg::RES_DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r;
  logic             pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[rp_r];
  assign pop       = out_valid && out_ready;
  assign room_o    = cnt_r <= CNT_W'(smrs_pkg::RES_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      q_r[wp_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      q_r[wp_r + PTR_W'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + PTR_W'(push_cnt);
      rp_r  <= rp_r + PTR_W'(pop);
      cnt_r <= cnt_r + CNT_W'(push_cnt) - CNT_W'(pop);
    end
  end

  `SMRS_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(smrs_pkg::RES_DEPTH))
  `SMRS_ASSERT_IMPL(a_push_room, push_cnt != 2'd0, cnt_r <= CNT_W'(smrs_pkg::RES_DEPTH - 2))

endmodule

`default_nettype wire

// File: rtl/smbios_memory_record_scanner_unit.sv
// path: a byte that closes a memory device record or ends the table shows its
// results on out_ch after passing the event register, then the result queue
// throughput: one table byte per cycle; input stalls only while a decode event waits
// for two free entries in the four-entry result queue
// reset: synchronous active-low rst_n clears parser, statistics and queue;
// captured record fields are not reset
// ----------------------------------------------------------------------------
// smbios_memory_record_scanner_unit
// scans an smbios table byte stream and reports memory device records
// ----------------------------------------------------------------------------
`default_nettype none

module smbios_memory_record_scanner_unit #(
  parameter int MAX_MODULES = 8
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  smrs_in_if.sink     in_ch,
  smrs_out_if.source  out_ch
);

  smrs_pkg::ev_t  ev;
  smrs_pkg::cap_t cap;
  smrs_pkg::res_t push0, push1, res;
  logic           ev_take;
  logic           room;
  logic [1:0]     push_cnt;

  smrs_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .table_byte (in_ch.table_byte),
    .last_byte  (in_ch.last_byte),
    .ev_take    (ev_take),
    .ev_o       (ev),
    .cap_o      (cap)
  );

  smrs_decoder #(
    .MAX_MODULES (MAX_MODULES)
  ) u_decoder (
    .clk      (clk),
    .rst_n    (rst_n),
    .ev_i     (ev),
    .cap_i    (cap),
    .room_i   (room),
    .ev_take  (ev_take),
    .push_cnt (push_cnt),
    .push0    (push0),
    .push1    (push1)
  );

  smrs_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (push0),
    .push1     (push1),
    .room_o    (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (res)
  );

  assign out_ch.kind              = res.kind;
  assign out_ch.module_size_bytes = res.module_size_bytes;
  assign out_ch.module_speed      = res.module_speed;
  assign out_ch.module_form_code  = res.module_form_code;
  assign out_ch.module_type_code  = res.module_type_code;
  assign out_ch.total_slots       = res.total_slots;
  assign out_ch.used_slots        = res.used_slots;
  assign out_ch.lowest_speed      = res.lowest_speed;
  assign out_ch.table_form_code   = res.table_form_code;
  assign out_ch.status            = res.status;
  assign out_ch.final_result      = res.final_result;

endmodule

`default_nettype wire

// File: tb/smbios_memory_record_scanner_unit_test.sv
// ----------------------------------------------------------------------------
// smbios_memory_record_scanner_unit_test
// streams smbios tables through the scanner byte by byte, with random sender
// gaps and receiver stalls, and checks every module report and table summary
// against a scanner model kept in step with each accepted table byte
// ----------------------------------------------------------------------------
module smbios_memory_record_scanner_unit_test;

  localparam int MODULE_LIMIT = 8;
  localparam int CAPTURE_BYTES = 92;
  localparam int RANDOM_BYTES = 200;
  localparam int RANDOM_REPORTS = 15;
  localparam int DRAIN_CYCLES = 16;
  localparam longint CYCLE_LIMIT = 200_000;

  localparam int OFF_SIZE = 'h0c;
  localparam int OFF_FORM = 'h0e;
  localparam int OFF_MTYPE = 'h12;
  localparam int OFF_RATED = 'h15;
  localparam int OFF_EXT_SIZE = 'h1c;
  localparam int OFF_CONF = 'h20;
  localparam int OFF_EXT_RATED = 'h54;
  localparam int OFF_EXT_CONF = 'h58;

  typedef enum logic [1:0] {SCAN_TYPE, SCAN_LEN, SCAN_BODY, SCAN_STRINGS} scan_phase_t;
  typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_mode_t;

  typedef struct {
    logic [7:0]  len;
    logic [15:0] size_word;
    logic [31:0] ext_size;
    logic [7:0]  form;
    logic [7:0]  mem_type;
    logic [15:0] rated;
    logic [15:0] conf;
    logic [31:0] ext_rated;
    logic [31:0] ext_conf;
  } memdev_t;

  logic clk;
  logic rst_n;

  smrs_in_if  in_ch();
  smrs_out_if out_ch();

  smbios_memory_record_scanner_unit #(.MAX_MODULES(MODULE_LIMIT)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // scanner model state
  scan_phase_t phase;
  logic [7:0]  rec_pos;
  logic [7:0]  rec_type;
  logic [7:0]  rec_len;
  logic [7:0]  rec_bytes [CAPTURE_BYTES];
  bit          prev_zero;
  bit          halted;
  logic [15:0] slots;
  logic [15:0] used;
  logic [7:0]  emitted_modules;
  logic [31:0] min_spd;
  logic [4:0]  first_form_code;

  smrs_pkg::res_t scan_reports_due [$];
  logic [7:0]     table_bytes [$];
  logic [7:0]     record_buf [256];

  int     mismatches = 0;
  int     bytes_sent = 0;
  int     reports_predicted = 0;
  int     hold_cycles = 0;
  int     burst_left = 0;
  bit     gaps_on = 1;
  longint cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("smbios_memory_record_scanner_unit_test: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  task automatic clear_scanner();
    phase = SCAN_TYPE;
    rec_pos = '0;
    rec_type = '0;
    rec_len = '0;
    foreach (rec_bytes[i]) rec_bytes[i] = '0;
    prev_zero = 0;
    halted = 0;
    slots = '0;
    used = '0;
    emitted_modules = '0;
    min_spd = '0;
    first_form_code = '0;
  endtask

  function automatic logic [7:0] rec8(int off);
    return (off < CAPTURE_BYTES) ? rec_bytes[7'(off)] : 8'h00;
  endfunction

  function automatic logic [15:0] rec16(int off);
    return {rec8(off + 1), rec8(off)};
  endfunction

  function automatic logic [31:0] rec32(int off);
    return {rec16(off + 2), rec16(off)};
  endfunction

  function automatic logic [51:0] decoded_size(logic [7:0] len);
    logic [15:0] enc;
    enc = rec16(OFF_SIZE);
    if (len <= smrs_pkg::LEN_SIZE || enc == 16'h0000 || enc == smrs_pkg::SIZE_NONE) return '0;
    if (enc == smrs_pkg::SIZE_EXT) begin
      return (len < smrs_pkg::LEN_EXT_SIZE) ? 52'h0 : {rec32(OFF_EXT_SIZE), 20'h0};
    end
    if (enc[15]) return {27'h0, enc[14:0], 10'h0};
    return {16'h0, enc, 20'h0};
  endfunction

  function automatic bit is_populated(logic [7:0] len);
    logic [15:0] enc;
    enc = rec16(OFF_SIZE);
    if (len <= smrs_pkg::LEN_SIZE || enc == 16'h0000 || enc == smrs_pkg::SIZE_NONE) return 0;
    if (enc != smrs_pkg::SIZE_EXT) return 1;
    return len >= smrs_pkg::LEN_EXT_SIZE && rec32(OFF_EXT_SIZE) != 32'h0;
  endfunction

  function automatic logic [31:0] decoded_speed(logic [7:0] len);
    logic [31:0] rated;
    logic [31:0] conf;
    rated = '0;
    conf = '0;
    if (len >= smrs_pkg::LEN_RATED) rated = 32'(rec16(OFF_RATED));
    if (len >= smrs_pkg::LEN_CONF) conf = 32'(rec16(OFF_CONF));
    if (rated == smrs_pkg::SPEED_EXT && len >= smrs_pkg::LEN_EXT_RATED) begin
      rated = rec32(OFF_EXT_RATED);
    end
    if (conf == smrs_pkg::SPEED_EXT && len >= smrs_pkg::LEN_EXT_CONF) begin
      conf = rec32(OFF_EXT_CONF);
    end
    if (conf == smrs_pkg::SPEED_EXT) conf = '0;
    if (rated == smrs_pkg::SPEED_EXT) rated = '0;
    return (conf != 0) ? conf : rated;
  endfunction

  task automatic close_record(output bit emitted, output smrs_pkg::res_t mod);
    logic [31:0] spd;
    logic [7:0]  form;
    emitted = 0;
    mod = '0;
    if (rec_type == smrs_pkg::TYPE_MEMDEV) begin
      if (slots != smrs_pkg::CNT_SAT) slots++;
      if (is_populated(rec_len)) begin
        spd = decoded_speed(rec_len);
        form = rec8(OFF_FORM);
        if (used != smrs_pkg::CNT_SAT) used++;
        if (spd != 0 && (min_spd == 0 || spd < min_spd)) min_spd = spd;
        if (first_form_code == 0 && rec_len > smrs_pkg::LEN_FORM && form >= 8'd1 &&
            form <= smrs_pkg::FORM_MAX && form != smrs_pkg::FORM_UNKNOWN) begin
          first_form_code = form[4:0];
        end
        if (emitted_modules < MODULE_LIMIT) begin
          emitted_modules++;
          mod.kind = smrs_pkg::KIND_MODULE;
          mod.module_size_bytes = decoded_size(rec_len);
          mod.module_speed = spd;
          mod.module_form_code = (rec_len > smrs_pkg::LEN_FORM) ? form : 8'h00;
          mod.module_type_code = (rec_len > smrs_pkg::LEN_MTYPE) ? rec8(OFF_MTYPE) : 8'h00;
          emitted = 1;
        end
      end
    end
    if (rec_type == smrs_pkg::TYPE_END) halted = 1;
    phase = SCAN_TYPE;
    rec_pos = '0;
    prev_zero = 0;
  endtask

  task automatic scan_table_byte(logic [7:0] b, bit last);
    bit             emitted;
    smrs_pkg::res_t mod;
    smrs_pkg::res_t summary;
    emitted = 0;
    if (!halted) begin
      case (phase)
        SCAN_TYPE: begin
          rec_type = b;
          rec_bytes[0] = b;
          rec_pos = 8'd1;
          phase = SCAN_LEN;
        end
        SCAN_LEN: begin
          rec_len = b;
          if (b < smrs_pkg::MIN_LEN) begin
            halted = 1;
          end else begin
            rec_bytes[1] = b;
            rec_pos = 8'd2;
            phase = SCAN_BODY;
          end
        end
        SCAN_BODY: begin
          if (rec_pos < CAPTURE_BYTES) rec_bytes[rec_pos[6:0]] = b;
          rec_pos = rec_pos + 8'd1;
          if (rec_pos >= rec_len) begin
            phase = SCAN_STRINGS;
            prev_zero = 0;
          end
        end
        default: begin
          if (b == 8'h00 && prev_zero) close_record(emitted, mod);
          else prev_zero = (b == 8'h00);
        end
      endcase
    end
    if (emitted) begin
      mod.final_result = !last;
      scan_reports_due.push_back(mod);
      reports_predicted++;
    end
    if (last) begin
      summary = '0;
      summary.kind = smrs_pkg::KIND_SUMMARY;
      summary.total_slots = slots;
      summary.used_slots = used;
      summary.lowest_speed = min_spd;
      summary.table_form_code = first_form_code;
      summary.status = (slots == 0);
      summary.final_result = 1'b1;
      scan_reports_due.push_back(summary);
      reports_predicted++;
      clear_scanner();
    end
  endtask

  // ---------------------------------------------------------------- checking

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    smrs_pkg::res_t got;
    smrs_pkg::res_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
      got.kind = out_ch.kind;
      got.module_size_bytes = out_ch.module_size_bytes;
      got.module_speed = out_ch.module_speed;
      got.module_form_code = out_ch.module_form_code;
      got.module_type_code = out_ch.module_type_code;
      got.total_slots = out_ch.total_slots;
      got.used_slots = out_ch.used_slots;
      got.lowest_speed = out_ch.lowest_speed;
      got.table_form_code = out_ch.table_form_code;
      got.status = out_ch.status;
      got.final_result = out_ch.final_result;
      if (scan_reports_due.size() == 0) begin
        $error("result transaction with nothing expected, kind 0x%0h", got.kind);
        mismatches++;
      end else begin
        want = scan_reports_due.pop_front();
        check_field("kind", 64'(want.kind), 64'(got.kind));
        check_field("module_size_bytes", 64'(want.module_size_bytes),
                    64'(got.module_size_bytes));
        check_field("module_speed", 64'(want.module_speed), 64'(got.module_speed));
        check_field("module_form_code", 64'(want.module_form_code),
                    64'(got.module_form_code));
        check_field("module_type_code", 64'(want.module_type_code),
                    64'(got.module_type_code));
        check_field("total_slots", 64'(want.total_slots), 64'(got.total_slots));
        check_field("used_slots", 64'(want.used_slots), 64'(got.used_slots));
        check_field("lowest_speed", 64'(want.lowest_speed), 64'(got.lowest_speed));
        check_field("table_form_code", 64'(want.table_form_code),
                    64'(got.table_form_code));
        check_field("status", 64'(want.status), 64'(got.status));
        check_field("final_result", 64'(want.final_result), 64'(got.final_result));
      end
    end
  end

  // result side stalls, plus a counted hold-off on request
  initial begin : result_receiver
    ready_mode_t mode;
    int          mode_left;
    mode = READY_ALWAYS;
    mode_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready = 1'b0;
        hold_cycles--;
      end else begin
        if (mode_left == 0) begin
          mode = ready_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 150);
        end else begin
          mode_left--;
        end
        case (mode)
          READY_ALWAYS: out_ch.ready = 1'b1;
          READY_COIN: out_ch.ready = 1'($urandom_range(0, 1));
          READY_SPARSE: out_ch.ready = ($urandom_range(0, 3) == 0);
          default: out_ch.ready = (mode_left % 3 == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_byte(logic [7:0] b, bit last);
    in_ch.valid = 1'b1;
    in_ch.table_byte = b;
    in_ch.last_byte = last;
    do @(posedge clk); while (!in_ch.ready);
    scan_table_byte(b, last);
    bytes_sent++;
    @(negedge clk);
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_ch.valid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(0, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_queued(bit closes_table);
    logic [7:0] b;
    while (table_bytes.size() != 0) begin
      b = table_bytes.pop_front();
      send_byte(b, closes_table && table_bytes.size() == 0);
    end
  endtask

  // drops trailing bytes to cut the table short
  task automatic send_table(int drop);
    repeat (drop) if (table_bytes.size() > 1) void'(table_bytes.pop_back());
    send_queued(1);
  endtask

  function automatic void place_le(int off, logic [31:0] v, int nbytes);
    for (int i = 0; i < nbytes; i++) record_buf[8'(off + i)] = v[8*i +: 8];
  endfunction

  task automatic put_record(logic [7:0] rtype, logic [7:0] len, memdev_t f, int strings);
    for (int i = 0; i < len; i++) record_buf[8'(i)] = 8'($urandom);
    record_buf[0] = rtype;
    record_buf[1] = len;
    if (rtype == smrs_pkg::TYPE_MEMDEV) begin
      place_le(OFF_SIZE, 32'(f.size_word), 2);
      place_le(OFF_FORM, 32'(f.form), 1);
      place_le(OFF_MTYPE, 32'(f.mem_type), 1);
      place_le(OFF_RATED, 32'(f.rated), 2);
      place_le(OFF_EXT_SIZE, f.ext_size, 4);
      place_le(OFF_CONF, 32'(f.conf), 2);
      place_le(OFF_EXT_RATED, f.ext_rated, 4);
      place_le(OFF_EXT_CONF, f.ext_conf, 4);
    end
    if (len < smrs_pkg::MIN_LEN) begin
      table_bytes.push_back(rtype);
      table_bytes.push_back(len);
    end else begin
      for (int i = 0; i < len; i++) table_bytes.push_back(record_buf[8'(i)]);
      for (int s = 0; s < strings; s++) begin
        repeat ($urandom_range(1, 8)) table_bytes.push_back(8'($urandom_range(1, 255)));
        table_bytes.push_back(8'h00);
      end
      if (strings == 0) table_bytes.push_back(8'h00);
      table_bytes.push_back(8'h00);
    end
  endtask

  function automatic memdev_t plain_memdev(logic [7:0] len);
    memdev_t f;
    f.len = len;
    f.size_word = 16'h0400;
    f.ext_size = '0;
    f.form = 8'd9;
    f.mem_type = 8'h1a;
    f.rated = 16'd3200;
    f.conf = 16'd2933;
    f.ext_rated = '0;
    f.ext_conf = '0;
    return f;
  endfunction

  function automatic logic [15:0] pick_narrow();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'($urandom_range(1, 8000));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_wide();
    case ($urandom_range(0, 4))
      0: return 32'h0;
      1: return smrs_pkg::SPEED_EXT;
      2: return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic memdev_t random_memdev();
    memdev_t    f;
    logic [7:0] edges [14] = '{8'h0d, 8'h0e, 8'h0f, 8'h12, 8'h13, 8'h16, 8'h17,
                               8'h1f, 8'h20, 8'h22, 8'h57, 8'h58, 8'h5b, 8'h5c};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: f.len = edges[4'($urandom_range(0, 13))];
      5, 6: f.len = 8'($urandom_range(4, 'h60));
      7: f.len = 8'($urandom_range(4, 255));
      default: f.len = smrs_pkg::LEN_CONF;
    endcase
    case ($urandom_range(0, 7))
      0: f.size_word = 16'h0000;
      1: f.size_word = smrs_pkg::SIZE_NONE;
      2: f.size_word = smrs_pkg::SIZE_EXT;
      3: f.size_word = {1'b1, 15'($urandom)};
      default: f.size_word = 16'($urandom_range(1, 'h7ffe));
    endcase
    f.ext_size = pick_wide();
    f.form = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 18));
    f.mem_type = 8'($urandom);
    f.rated = pick_narrow();
    f.conf = pick_narrow();
    f.ext_rated = pick_wide();
    f.ext_conf = pick_wide();
    return f;
  endfunction

  task automatic one_record(memdev_t f);
    put_record(smrs_pkg::TYPE_MEMDEV, f.len, f, 1);
    send_table(0);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_empty_tables();
    send_byte(8'h00, 1);
    send_byte(8'hff, 1);
    send_byte(smrs_pkg::TYPE_MEMDEV, 1);
  endtask

  task automatic test_size_encodings();
    memdev_t     f;
    logic [15:0] words [10] = '{16'h0000, 16'hffff, 16'h7fff, 16'h7fff, 16'h7fff,
                                16'h8000, 16'hfffe, 16'h7ffe, 16'h0001, 16'h8001};
    logic [31:0] exts [10] = '{32'h0, 32'h0, 32'h0, 32'hffffffff, 32'h00000010,
                               32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
    for (int i = 0; i < 10; i++) begin
      f = plain_memdev(smrs_pkg::LEN_EXT_SIZE);
      f.size_word = words[i];
      f.ext_size = exts[i];
      one_record(f);
    end
    // extended size word in a record too short to hold the extended size
    f = plain_memdev(smrs_pkg::LEN_EXT_SIZE - 8'd1);
    f.size_word = smrs_pkg::SIZE_EXT;
    f.ext_size = 32'h1000;
    one_record(f);
  endtask

  task automatic test_record_lengths();
    memdev_t    f;
    logic [7:0] lens [17] = '{8'h04, 8'h0d, 8'h0e, 8'h0f, 8'h12, 8'h13, 8'h16, 8'h17, 8'h1f,
                              8'h20, 8'h21, 8'h22, 8'h57, 8'h58, 8'h5b, 8'h5c, 8'h5d};
    for (int i = 0; i < 17; i++) begin
      f = plain_memdev(lens[i]);
      f.rated = 16'hffff;
      f.conf = (i % 2) ? 16'hffff : 16'h0000;
      f.ext_rated = 32'd4800;
      f.ext_conf = 32'd6400;
      one_record(f);
    end
  endtask

  task automatic test_speed_and_form();
    memdev_t f;
    f = plain_memdev(smrs_pkg::LEN_EXT_RATED);
    f.rated = 16'hffff;
    f.conf = 16'h0000;
    f.ext_rated = 32'hffffffff;
    one_record(f);
    f.ext_rated = smrs_pkg::SPEED_EXT;
    one_record(f);
    f = plain_memdev(smrs_pkg::LEN_EXT_CONF);
    f.conf = 16'hffff;
    f.ext_conf = 32'h0;
    one_record(f);
    f.ext_conf = 32'd8000;
    one_record(f);
    f = plain_memdev(smrs_pkg::LEN_EXT_CONF - 8'd1);
    f.conf = 16'hffff;
    one_record(f);
    // unknown and out-of-range form codes never become the table form
    f = plain_memdev(smrs_pkg::LEN_CONF);
    f.form = smrs_pkg::FORM_UNKNOWN;
    put_record(smrs_pkg::TYPE_MEMDEV, f.len, f, 0);
    f.form = smrs_pkg::FORM_MAX + 8'd1;
    put_record(smrs_pkg::TYPE_MEMDEV, f.len, f, 2);
    f.form = 8'h00;
    f.rated = 16'h0000;
    f.conf = 16'h0000;
    put_record(smrs_pkg::TYPE_MEMDEV, f.len, f, 0);
    f.form = smrs_pkg::FORM_MAX;
    f.mem_type = 8'hff;
    f.conf = 16'd2400;
    put_record(smrs_pkg::TYPE_MEMDEV, f.len, f, 1);
    f.form = 8'd1;
    f.conf = 16'd5200;
    put_record(smrs_pkg::TYPE_MEMDEV, f.len, f, 0);
    send_table(0);
  endtask

  task automatic test_short_length();
    memdev_t f;
    f = plain_memdev(smrs_pkg::LEN_CONF);
    put_record(8'd4, 8'd6, f, 1);
    put_record(smrs_pkg::TYPE_MEMDEV, smrs_pkg::MIN_LEN - 8'd1, f, 0);
    put_record(smrs_pkg::TYPE_MEMDEV, f.len, f, 1);
    send_table(0);
    put_record(smrs_pkg::TYPE_MEMDEV, f.len, f, 0);
    put_record(smrs_pkg::TYPE_MEMDEV, 8'd0, f, 0);
    repeat (6) table_bytes.push_back(8'($urandom));
    send_table(0);
  endtask

  task automatic test_end_record();
    memdev_t f;
    f = plain_memdev(smrs_pkg::LEN_CONF);
    put_record(smrs_pkg::TYPE_MEMDEV, f.len, f, 1);
    put_record(smrs_pkg::TYPE_END, smrs_pkg::MIN_LEN, f, 0);
    put_record(smrs_pkg::TYPE_MEMDEV, f.len, f, 1);
    send_table(0);
    // end record not closed before the table ends
    put_record(smrs_pkg::TYPE_MEMDEV, f.len, f, 0);
    put_record(smrs_pkg::TYPE_END, smrs_pkg::MIN_LEN, f, 0);
    send_table(1);
  endtask

  task automatic test_cut_off();
    memdev_t f;
    f = plain_memdev(smrs_pkg::LEN_CONF);
    put_record(smrs_pkg::TYPE_MEMDEV, f.len, f, 0);
    put_record(smrs_pkg::TYPE_MEMDEV, f.len, f, 0);
    send_table(7);
    put_record(smrs_pkg::TYPE_MEMDEV, f.len, f, 2);
    send_table(1);
  endtask

  task automatic test_module_limit();
    memdev_t f;
    for (int i = 0; i < MODULE_LIMIT + 3; i++) begin
      f = plain_memdev(smrs_pkg::LEN_CONF);
      f.conf = 16'($urandom_range(1, 'hfffe));
      f.form = 8'($urandom_range(0, 18));
      put_record(smrs_pkg::TYPE_MEMDEV, f.len, f, $urandom_range(0, 2));
    end
    send_table(0);
  endtask

  task automatic test_long_record();
    memdev_t f;
    f = plain_memdev(8'hff);
    f.rated = 16'hffff;
    f.ext_rated = 32'd5600;
    f.conf = 16'h0000;
    put_record(smrs_pkg::TYPE_MEMDEV, f.len, f, 3);
    put_record(8'd2, 8'hff, f, 2);
    send_table(0);
  endtask

  // results back up while the receiver holds off, so the input must stall
  task automatic test_input_stall();
    memdev_t f;
    gaps_on = 0;
    hold_cycles = 400;
    for (int i = 0; i < MODULE_LIMIT + 2; i++) begin
      f = plain_memdev(smrs_pkg::LEN_FORM + 8'd1);
      f.size_word = 16'($urandom_range(1, 'h7ffe));
      put_record(smrs_pkg::TYPE_MEMDEV, f.len, f, 0);
    end
    send_table(0);
    gaps_on = 1;
  endtask

  task automatic test_random_tables();
    int      byte_goal;
    int      report_goal;
    int      k;
    memdev_t f;
    byte_goal = bytes_sent + RANDOM_BYTES;
    report_goal = reports_predicted + RANDOM_REPORTS;
    while (bytes_sent < byte_goal || reports_predicted < report_goal) begin
      if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(1, 40)) table_bytes.push_back(8'($urandom));
        send_table(0);
      end else begin
        repeat ($urandom_range(1, 10)) begin
          k = $urandom_range(0, 99);
          f = random_memdev();
          if (k < 60) begin
            put_record(smrs_pkg::TYPE_MEMDEV, f.len, f, $urandom_range(0, 3));
          end else if (k < 90) begin
            put_record(8'($urandom), 8'($urandom_range(4, 40)), f, $urandom_range(0, 3));
          end else if (k < 94) begin
            put_record(smrs_pkg::TYPE_END, 8'($urandom_range(4, 8)), f, $urandom_range(0, 1));
          end else if (k < 97) begin
            put_record(8'($urandom), 8'($urandom_range(0, 3)), f, 0);
          end else begin
            repeat ($urandom_range(1, 6)) table_bytes.push_back(8'($urandom));
          end
        end
        send_table(($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : 0);
      end
    end
  endtask

  initial begin : run_tests
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.table_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    clear_scanner();
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_empty_tables();
    test_size_encodings();
    test_record_lengths();
    test_speed_and_form();
    test_short_length();
    test_end_record();
    test_cut_off();
    test_module_limit();
    test_long_record();
    test_input_stall();
    test_random_tables();

    in_ch.valid = 1'b0;
    in_ch.last_byte = 1'b0;
    while (scan_reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("smbios_memory_record_scanner_unit_test: done, clean");
    end else begin
      $display("smbios_memory_record_scanner_unit_test: done, errors");
    end
    $finish;
  end

endmodule
